[hdl/fgia_pkg.sv]
// Shared widths, register codes and reset values for the flex group inode allocator.
// No dependencies; fgia_if, fgia_div, top and checker use scoped names, tb imports it.
package fgia_pkg;

	// Payload widths
	localparam int PARENT_W = 18;
	localparam int IPG_W    = 14;
	localparam int LOG_W    = 3;
	localparam int GC_W     = 5;
	localparam int TOTAL_W  = 18;

	// Configuration port
	localparam int CFG_DATA_W = 14;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_IPG = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOG = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GC  = 2'd2;

	localparam logic [IPG_W-1:0] IPG_RESET = 14'd8192;
	localparam logic [LOG_W-1:0] LOG_RESET = 3'd4;
	localparam logic [GC_W-1:0]  GC_RESET  = 5'd16;

	// Smallest usable group size
	localparam logic [IPG_W-1:0] IPG_MIN = 14'd8;

	// Default sizing of the storage
	localparam int NUM_GROUPS_DEF = 16;
	localparam int MAX_IPG_DEF    = 8192;
	localparam int WORD_BITS_DEF  = 32;

endpackage

[hdl/fgia_if.sv]
// Valid/ready channel interfaces for the allocator's request and response words.
// Depends on fgia_pkg for the payload widths.
interface fgia_req_if;
	logic                           valid;
	logic                           ready;
	logic [fgia_pkg::PARENT_W-1:0]  parent_inode;

	modport source (output valid, output parent_inode, input ready);
	modport sink   (input valid, input parent_inode, output ready);
endinterface

interface fgia_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           found;
	logic [fgia_pkg::PARENT_W-1:0]  new_inode;
	logic [fgia_pkg::IPG_W-1:0]     group_free;
	logic [fgia_pkg::TOTAL_W-1:0]   total_allocated;

	modport source (output valid, output found, output new_inode, output group_free,
		output total_allocated, input ready);
	modport sink   (input valid, input found, input new_inode, input group_free,
		input total_allocated, output ready);
endinterface

[hdl/fgia_ram.sv]
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// No dependencies.
module fgia_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[hdl/fgia_div.sv]
// Restoring divider, one quotient bit per cycle: parent offset over group size.
// Depends on fgia_pkg for the operand widths.
module fgia_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [fgia_pkg::PARENT_W-1:0]  dividend,
	input  logic [fgia_pkg::IPG_W-1:0]     divisor,
	output logic                           done,
	output logic [fgia_pkg::PARENT_W-1:0]  quotient
);

	localparam int QW    = fgia_pkg::PARENT_W;
	localparam int RW    = fgia_pkg::IPG_W;
	localparam int CNT_W = $clog2(QW);

	logic [QW-1:0]    quo_q;
	logic [RW-1:0]    rem_q;
	logic [RW-1:0]    dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [RW:0]      trial;
	logic             ge;
	logic [RW-1:0]    rem_nxt;

	// One trial subtraction per step
	always_comb begin
		trial   = {rem_q, quo_q[QW-1]};
		ge      = trial >= {1'b0, dvs_q};
		rem_nxt = ge ? RW'(trial - {1'b0, dvs_q}) : trial[RW-1:0];
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: dividend shifts out of the top while quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[QW-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[hdl/fgia_ffz.sv]
// Find-first-zero over one bitmap word, ignoring bits past the end of the group.
// No dependencies.
module fgia_ffz #(
	parameter int WORD_BITS = 32
) (
	input  logic [WORD_BITS-1:0]           word,
	input  logic [$clog2(WORD_BITS+1)-1:0] lim,
	output logic                           hit,
	output logic [$clog2(WORD_BITS)-1:0]   idx
);

	localparam int LIM_W = $clog2(WORD_BITS + 1);
	localparam int BIT_W = $clog2(WORD_BITS);

	logic [WORD_BITS-1:0] free;

	// Free and inside the group
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			free[b] = !word[b] && (LIM_W'(b) < lim);
		end
	end

	// Lowest free bit wins
	always_comb begin
		hit = |free;
		idx = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (free[b]) begin
				idx = BIT_W'(b);
			end
		end
	end

endmodule

[hdl/flex_group_inode_allocator.sv]
// Top level of the flex group inode allocator: config registers, sequencer, memories.
// Depends on fgia_pkg, fgia_if, fgia_ram, fgia_div and fgia_ffz.
//
// Usage:
//   req carries parent_inode; rsp returns found, new_inode, group_free and
//   total_allocated, one response word per request word, in order.
//   Config is written through cfg_wr_en/cfg_index/cfg_data while idle.
// Steps per request:
//   an accept state, the divider for the parent's group (18 steps and the
//   done flag), a range state, then per group of the flex range a group
//   state plus a read and a check per bitmap word, a state to form the
//   result and a load of the response register.
//   The bitmap scan, one word read and then checked at a time, sets the
//   request length: a first-group hit in word 0 ends soonest, a full
//   16-group range of 256 words each (group 0 skipped) takes longest.
//   A request with parent_inode 0 skips the divider and the scan.
// Reset:
//   All counts go to zero, config to 8192 / 4 / 16, and a clearing pass
//   writes zero to every bitmap word (NUM_GROUPS * words per group words,
//   4096 with the defaults); req.ready stays low until it ends.
// Stall:
//   A finished response waits in the output register; the next request is
//   accepted meanwhile and held at its result until the register frees.
module flex_group_inode_allocator #(
	parameter int NUM_GROUPS           = fgia_pkg::NUM_GROUPS_DEF,
	parameter int MAX_INODES_PER_GROUP = fgia_pkg::MAX_IPG_DEF,
	parameter int BITMAP_WORD_BITS     = fgia_pkg::WORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [fgia_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fgia_pkg::CFG_DATA_W-1:0]  cfg_data,
	fgia_req_if.sink                         req,
	fgia_rsp_if.source                       rsp
);

	localparam int PARENT_W = fgia_pkg::PARENT_W;
	localparam int IPG_W    = fgia_pkg::IPG_W;
	localparam int TOTAL_W  = fgia_pkg::TOTAL_W;
	localparam int WPG      = (MAX_INODES_PER_GROUP + BITMAP_WORD_BITS - 1) / BITMAP_WORD_BITS;
	localparam int DEPTH    = NUM_GROUPS * WPG;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int GRP_W    = $clog2(NUM_GROUPS);
	localparam int GCNT_W   = $clog2(NUM_GROUPS + 1);
	localparam int WRD_W    = (WPG > 1) ? $clog2(WPG) : 1;
	localparam int BIT_W    = $clog2(BITMAP_WORD_BITS);
	localparam int LIM_W    = $clog2(BITMAP_WORD_BITS + 1);
	localparam int SIDX_W   = WRD_W + BIT_W;
	localparam int INO_W    = GRP_W + IPG_W + 1;

	// Sequencer states
	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_RANGE = 4'd3;
	localparam logic [3:0] S_GRP   = 4'd4;
	localparam logic [3:0] S_RD    = 4'd5;
	localparam logic [3:0] S_CHK   = 4'd6;
	localparam logic [3:0] S_FIN   = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;

	logic [3:0]                  state_q;
	logic [ADDR_W-1:0]           clr_q;
	logic [IPG_W-1:0]            ipg_q;
	logic [fgia_pkg::LOG_W-1:0]  log_q;
	logic [fgia_pkg::GC_W-1:0]   gc_q;
	logic [GCNT_W-1:0]           g_q;
	logic [GCNT_W-1:0]           end_q;
	logic [WRD_W-1:0]            widx_q;
	logic [SIDX_W-1:0]           hit_s_q;
	logic [IPG_W-1:0]            used_q;
	logic [TOTAL_W-1:0]          total_q;
	logic                        res_found_q;
	logic [PARENT_W-1:0]         res_inode_q;
	logic [IPG_W-1:0]            res_free_q;
	logic                        out_valid_q;
	logic                        out_found_q;
	logic [PARENT_W-1:0]         out_inode_q;
	logic [IPG_W-1:0]            out_free_q;
	logic [TOTAL_W-1:0]          out_total_q;

	logic [IPG_W-1:0]            ipg_eff;
	logic [GCNT_W-1:0]           gc_eff;
	logic                        req_acc;
	logic                        div_start;
	logic                        div_done;
	logic [PARENT_W-1:0]         div_quo;
	logic [PARENT_W-1:0]         flex_mask;
	logic [PARENT_W-1:0]         start_grp;
	logic [PARENT_W:0]           end_grp;
	logic [PARENT_W:0]           gc_ext;
	logic                        range_empty;
	logic [GCNT_W-1:0]           end_clamp;
	logic [GRP_W-1:0]            g_idx;
	logic [WRD_W-1:0]            last_word;
	logic [IPG_W:0]              base_bits;
	logic [IPG_W:0]              rem_bits;
	logic [LIM_W-1:0]            lim;
	logic [ADDR_W-1:0]           addr_cur;
	logic                        bm_we;
	logic [ADDR_W-1:0]           bm_waddr;
	logic [BITMAP_WORD_BITS-1:0] bm_wdata;
	logic [BITMAP_WORD_BITS-1:0] bm_rdata;
	logic                        gu_we;
	logic [GRP_W-1:0]            gu_waddr;
	logic [IPG_W-1:0]            gu_wdata;
	logic [IPG_W-1:0]            gu_rdata;
	logic                        ffz_hit;
	logic [BIT_W-1:0]            ffz_idx;
	logic [IPG_W-1:0]            used_nxt;
	logic [INO_W-1:0]            inode_full;
	logic                        out_free;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ipg_q <= fgia_pkg::IPG_RESET;
			log_q <= fgia_pkg::LOG_RESET;
			gc_q  <= fgia_pkg::GC_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				fgia_pkg::CFG_IPG: ipg_q <= cfg_data[IPG_W-1:0];
				fgia_pkg::CFG_LOG: log_q <= cfg_data[fgia_pkg::LOG_W-1:0];
				fgia_pkg::CFG_GC:  gc_q  <= cfg_data[fgia_pkg::GC_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective group size and group count
	always_comb begin
		if (ipg_q < fgia_pkg::IPG_MIN) begin
			ipg_eff = fgia_pkg::IPG_MIN;
		end else if (32'(ipg_q) > 32'(MAX_INODES_PER_GROUP)) begin
			ipg_eff = IPG_W'(MAX_INODES_PER_GROUP);
		end else begin
			ipg_eff = ipg_q;
		end
		if (32'(gc_q) > 32'(NUM_GROUPS)) begin
			gc_eff = GCNT_W'(NUM_GROUPS);
		end else begin
			gc_eff = GCNT_W'(gc_q);
		end
	end

	// Parent group = (parent - 1) / group size
	assign req_acc   = req.valid && req.ready;
	assign div_start = req_acc && (req.parent_inode != '0);

	fgia_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (req.parent_inode - PARENT_W'(1)),
		.divisor  (ipg_eff),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Flex range, clipped to the group count
	always_comb begin
		flex_mask   = (PARENT_W'(1) << log_q) - PARENT_W'(1);
		start_grp   = div_quo & ~flex_mask;
		end_grp     = {1'b0, start_grp} + {1'b0, flex_mask} + (PARENT_W+1)'(1);
		gc_ext      = (PARENT_W+1)'(gc_eff);
		range_empty = {1'b0, start_grp} >= gc_ext;
		end_clamp   = (end_grp > gc_ext) ? gc_eff : GCNT_W'(end_grp);
	end

	// Word address and the valid-bit limit of the current word
	always_comb begin
		g_idx     = g_q[GRP_W-1:0];
		last_word = WRD_W'((ipg_eff - IPG_W'(1)) >> BIT_W);
		addr_cur  = ADDR_W'(g_idx * ADDR_W'(WPG)) + ADDR_W'(widx_q);
		base_bits = (IPG_W+1)'(widx_q) << BIT_W;
		rem_bits  = {1'b0, ipg_eff} - base_bits;
		lim       = (rem_bits >= (IPG_W+1)'(BITMAP_WORD_BITS)) ?
			LIM_W'(BITMAP_WORD_BITS) : LIM_W'(rem_bits);
	end

	fgia_ffz #(
		.WORD_BITS (BITMAP_WORD_BITS)
	) u_ffz (
		.word (bm_rdata),
		.lim  (lim),
		.hit  (ffz_hit),
		.idx  (ffz_idx)
	);

	// Memory write ports: clearing pass or read-modify-write on a hit
	always_comb begin
		used_nxt = gu_rdata + IPG_W'(1);
		if (state_q == S_CLEAR) begin
			bm_we    = 1'b1;
			bm_waddr = clr_q;
			bm_wdata = '0;
			gu_we    = 32'(clr_q) < 32'(NUM_GROUPS);
			gu_waddr = GRP_W'(clr_q);
			gu_wdata = '0;
		end else begin
			bm_we    = (state_q == S_CHK) && ffz_hit;
			bm_waddr = addr_cur;
			bm_wdata = bm_rdata | (BITMAP_WORD_BITS'(1) << ffz_idx);
			gu_we    = bm_we;
			gu_waddr = g_idx;
			gu_wdata = used_nxt;
		end
	end

	fgia_ram #(
		.WIDTH (BITMAP_WORD_BITS),
		.DEPTH (DEPTH)
	) u_bitmap (
		.clk   (clk),
		.we    (bm_we),
		.waddr (bm_waddr),
		.wdata (bm_wdata),
		.raddr (addr_cur),
		.rdata (bm_rdata)
	);

	fgia_ram #(
		.WIDTH (IPG_W),
		.DEPTH (NUM_GROUPS)
	) u_group_used (
		.clk   (clk),
		.we    (gu_we),
		.waddr (gu_waddr),
		.wdata (gu_wdata),
		.raddr (g_idx),
		.rdata (gu_rdata)
	);

	assign inode_full = INO_W'(g_idx) * INO_W'(ipg_eff) + INO_W'(hit_s_q) + INO_W'(1);
	assign out_free   = !out_valid_q || rsp.ready;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			total_q     <= '0;
			res_found_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_acc) begin
						if (req.parent_inode == '0) begin
							res_found_q <= 1'b0;
							state_q     <= S_OUT;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_RANGE;
					end
				end
				S_RANGE: begin
					if (range_empty) begin
						res_found_q <= 1'b0;
						state_q     <= S_OUT;
					end else begin
						state_q <= S_GRP;
					end
				end
				S_GRP: begin
					if (g_q >= end_q) begin
						res_found_q <= 1'b0;
						state_q     <= S_OUT;
					end else if (g_q != '0) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (ffz_hit) begin
						total_q <= total_q + TOTAL_W'(1);
						state_q <= S_FIN;
					end else if (widx_q == last_word) begin
						state_q <= S_GRP;
					end else begin
						state_q <= S_RD;
					end
				end
				S_FIN: begin
					res_found_q <= 1'b1;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Scan position and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_RANGE: begin
				g_q   <= GCNT_W'(start_grp);
				end_q <= end_clamp;
			end
			S_GRP: begin
				widx_q <= '0;
				if (g_q < end_q && g_q == '0) begin
					g_q <= g_q + GCNT_W'(1);
				end
			end
			S_CHK: begin
				if (ffz_hit) begin
					hit_s_q <= {widx_q, ffz_idx};
					used_q  <= used_nxt;
				end else if (widx_q == last_word) begin
					g_q <= g_q + GCNT_W'(1);
				end else begin
					widx_q <= widx_q + WRD_W'(1);
				end
			end
			S_FIN: begin
				res_inode_q <= PARENT_W'(inode_full);
				res_free_q  <= (used_q >= ipg_eff) ? '0 : ipg_eff - used_q;
			end
			default: ;
		endcase
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_found_q <= res_found_q;
			out_inode_q <= res_found_q ? res_inode_q : '0;
			out_free_q  <= res_found_q ? res_free_q : '0;
			out_total_q <= total_q;
		end
	end

	assign req.ready           = (state_q == S_IDLE);
	assign rsp.valid           = out_valid_q;
	assign rsp.found           = out_found_q;
	assign rsp.new_inode       = out_inode_q;
	assign rsp.group_free      = out_free_q;
	assign rsp.total_allocated = out_total_q;

endmodule

[hdl/fgia_chk.sv]
// Port-level checker for the flex group inode allocator, bound to the top level.
// Depends on fgia_pkg for the payload widths.
module fgia_chk (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	input  logic                           req_ready,
	input  logic                           rsp_valid,
	input  logic                           rsp_ready,
	input  logic                           found,
	input  logic [fgia_pkg::PARENT_W-1:0]  new_inode,
	input  logic [fgia_pkg::IPG_W-1:0]     group_free,
	input  logic [fgia_pkg::TOTAL_W-1:0]   total_allocated
);

	logic [fgia_pkg::TOTAL_W-1:0] prev_total_q;
	logic [1:0]                   pend_q;
	logic                         req_acc;
	logic                         rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// Words accepted but not yet answered, and the last delivered total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= '0;
			prev_total_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(req_acc) - 2'(rsp_acc);
			if (rsp_acc) begin
				prev_total_q <= total_allocated;
			end
		end
	end

	// A stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(found) && $stable(new_inode)
			&& $stable(group_free) && $stable(total_allocated))
		else $error("response changed while stalled");

	// Every response answers an accepted request
	a_rsp_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("response without a pending request");

	// Not found carries zero inode and zero free count; found carries a real inode
	a_found_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (found ? (new_inode != '0)
			: (new_inode == '0 && group_free == '0)))
		else $error("result fields disagree with found");

	// The running total moves by exactly one per successful allocation
	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> total_allocated == prev_total_q + fgia_pkg::TOTAL_W'(found))
		else $error("total_allocated out of step");

endmodule

bind flex_group_inode_allocator fgia_chk u_fgia_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.found           (rsp.found),
	.new_inode       (rsp.new_inode),
	.group_free      (rsp.group_free),
	.total_allocated (rsp.total_allocated)
);

[tb/tb.sv]
// Testbench for flex_group_inode_allocator: directed and random allocation requests,
// each response word checked field by field against an allocator model kept in the bench.
// Depends on fgia_pkg, the fgia_req_if / fgia_rsp_if interfaces and the allocator RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fgia_pkg::*;

	localparam int NGROUPS     = NUM_GROUPS_DEF;
	localparam int MAXIPG      = MAX_IPG_DEF;
	localparam int IDLE_LIMIT  = 50000;
	localparam int HOLD_CYCLES = 400;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic                found;
		logic [PARENT_W-1:0] new_inode;
		logic [IPG_W-1:0]    group_free;
		logic [TOTAL_W-1:0]  total_allocated;
	} alloc_word_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	fgia_req_if req_ch();
	fgia_rsp_if rsp_ch();

	flex_group_inode_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Shadow of the registers and of the allocation state
	logic [IPG_W-1:0] ipg_reg;
	logic [LOG_W-1:0] log_reg;
	logic [GC_W-1:0]  gc_reg;
	bit               inode_taken [NGROUPS][MAXIPG];
	int unsigned      used_in_group [NGROUPS];
	int unsigned      inodes_total;

	logic [PARENT_W-1:0] parent_queue [$];
	alloc_word_t         alloc_expected [$];
	int unsigned         errors;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Group size after clamping into the supported range
	function automatic int unsigned group_size();
		int unsigned v;
		v = ipg_reg;
		if (v < IPG_MIN) v = IPG_MIN;
		if (v > MAXIPG) v = MAXIPG;
		return v;
	endfunction

	// Allocate for one request word in the shadow state and return the response word
	function automatic alloc_word_t predict_alloc(input logic [PARENT_W-1:0] parent);
		alloc_word_t r;
		int unsigned ipg, gc, flex, pg, first_g, stop_g, g, s, slot;
		bit hit;
		r = '0;
		ipg = group_size();
		gc = (gc_reg > NGROUPS) ? NGROUPS : gc_reg;
		flex = 32'd1 << log_reg;
		if (parent != '0) begin
			pg = (parent - 1) / ipg;
			first_g = pg - (pg % flex);
			stop_g = first_g + flex;
			if (stop_g > gc) stop_g = gc;
			// group 0 is never scanned
			for (g = first_g; g < stop_g && !r.found; g++) begin
				if (g != 0) begin
					hit = 1'b0;
					slot = 0;
					for (s = 0; s < ipg; s++)
						if (!hit && !inode_taken[g][s]) begin
							hit = 1'b1;
							slot = s;
						end
					if (hit) begin
						inode_taken[g][slot] = 1'b1;
						used_in_group[g] = (used_in_group[g] + 1) & 32'h3FFF;
						inodes_total = (inodes_total + 1) & 32'h3FFFF;
						r.found = 1'b1;
						r.new_inode = PARENT_W'(g * ipg + slot + 1);
						r.group_free = (used_in_group[g] >= ipg) ? '0 :
							IPG_W'(ipg - used_in_group[g]);
					end
				end
			end
		end
		r.total_allocated = TOTAL_W'(inodes_total);
		return r;
	endfunction

	// Random parent: mostly inside the present groups, some zero, some anywhere
	function automatic logic [PARENT_W-1:0] pick_parent();
		int unsigned ipg, gc, roll;
		ipg = group_size();
		gc = (gc_reg > NGROUPS) ? NGROUPS : gc_reg;
		if (gc == 0) gc = 1;
		roll = $urandom_range(0, 99);
		if (roll < 3) return '0;
		if (roll < 13) return PARENT_W'($urandom());
		return PARENT_W'($urandom_range(0, gc - 1) * ipg + $urandom_range(0, ipg - 1) + 1);
	endfunction

	// One register write; unused high data bits carry noise
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		logic [CFG_DATA_W-1:0] data;
		data = CFG_DATA_W'($urandom());
		case (idx)
			CFG_IPG: begin
				data = value[IPG_W-1:0];
				ipg_reg = value[IPG_W-1:0];
			end
			CFG_LOG: begin
				data[LOG_W-1:0] = value[LOG_W-1:0];
				log_reg = value[LOG_W-1:0];
			end
			CFG_GC: begin
				data[GC_W-1:0] = value[GC_W-1:0];
				gc_reg = value[GC_W-1:0];
			end
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
	endtask

	task automatic set_config(input int unsigned ipg, input int unsigned lg,
		input int unsigned gc);
		write_reg(CFG_IPG, ipg);
		write_reg(CFG_LOG, lg);
		write_reg(CFG_GC, gc);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Block is idle once nothing is queued, offered or outstanding
	task automatic wait_idle();
		do @(negedge clk);
		while (parent_queue.size() != 0 || req_ch.valid || alloc_expected.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic run_random(input int unsigned ipg, input int unsigned lg,
		input int unsigned gc, input int unsigned count, input bit poke_unused);
		wait_idle();
		if (poke_unused) write_reg(CFG_UNUSED, 0);
		set_config(ipg, lg, gc);
		@(negedge clk);
		repeat (count) parent_queue.push_back(pick_parent());
	endtask

	// Sender: bursts of random length separated by random gaps
	int unsigned burst_left;
	int unsigned gap_left;
	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (gap_left != 0) begin
				gap_left--;
				req_ch.valid <= 1'b0;
			end else if (parent_queue.size() != 0) begin
				req_ch.valid <= 1'b1;
				req_ch.parent_inode <= parent_queue.pop_front();
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: rotating stall pattern, plus two long hold-offs to back up the input
	logic [7:0]  ready_pattern;
	int unsigned pattern_age;
	int unsigned hold_left;
	int unsigned rsp_seen;
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			ready_pattern = 8'hFF;
			pattern_age = 0;
			hold_left = 0;
			rsp_seen = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				rsp_seen++;
				if (rsp_seen == 60 || rsp_seen == 400) hold_left = HOLD_CYCLES;
			end
			if (pattern_age == 0) begin
				pattern_age = $urandom_range(16, 96);
				ready_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom()) | 8'h01);
			end else begin
				pattern_age--;
			end
			ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
			if (hold_left != 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ready_pattern[0];
			end
		end
	end

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Monitor: check response words first, then predict for accepted requests
	always @(posedge clk) begin : monitor_blk
		alloc_word_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (alloc_expected.size() == 0) begin
					errors++;
					$display("%0t: response word with none expected: found %0b new_inode %0d",
						$time, rsp_ch.found, rsp_ch.new_inode);
				end else begin
					want = alloc_expected.pop_front();
					check_field("found", want.found, rsp_ch.found);
					check_field("new_inode", want.new_inode, rsp_ch.new_inode);
					check_field("group_free", want.group_free, rsp_ch.group_free);
					check_field("total_allocated", want.total_allocated,
						rsp_ch.total_allocated);
				end
			end
			if (req_ch.valid && req_ch.ready)
				alloc_expected.push_back(predict_alloc(req_ch.parent_inode));
		end
	end

	// Watchdog on cycles with no word moving on either channel
	int unsigned quiet_cycles;
	initial quiet_cycles = 0;
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == IDLE_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_IPG;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.parent_inode = '0;
		rsp_ch.ready = 1'b0;
		ipg_reg = IPG_RESET;
		log_reg = LOG_RESET;
		gc_reg = GC_RESET;
		inodes_total = 0;
		errors = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset registers: zero parent, parent beyond the groups, top and group-0 parents
		parent_queue.push_back(18'd1);
		parent_queue.push_back(18'd0);
		parent_queue.push_back(18'h3FFFF);
		parent_queue.push_back(18'd131072);
		parent_queue.push_back(18'd8193);
		parent_queue.push_back(18'd8192);
		parent_queue.push_back(18'd16385);
		parent_queue.push_back(18'd122881);

		// Smallest groups, one group per flex: fill group 1 until not found,
		// group 0 alone, and a parent group past the count
		wait_idle();
		set_config(8, 0, 2);
		@(negedge clk);
		repeat (9) parent_queue.push_back(18'd9);
		parent_queue.push_back(18'd1);
		parent_queue.push_back(18'd17);

		// Group size below the minimum with no groups present
		wait_idle();
		set_config(0, 7, 0);
		@(negedge clk);
		parent_queue.push_back(18'd5);

		// Group size above the maximum, widest flex, group count above the limit
		wait_idle();
		set_config(16383, 7, 31);
		@(negedge clk);
		parent_queue.push_back(18'd1);
		parent_queue.push_back(18'h3FFFF);

		// Random phases over a range of settings; state carries across them
		run_random(8192, 4, 16, 80, 1'b1);
		run_random(8, 1, 16, 120, 1'b0);
		run_random(16383, 7, 31, 60, 1'b0);
		run_random(37, 2, 9, 100, 1'b0);
		run_random(0, 3, 5, 60, 1'b0);
		run_random(100, 0, 0, 30, 1'b0);
		run_random(520, 4, 16, 120, 1'b0);
		run_random(64, 2, 12, 100, 1'b0);
		run_random(8192, 5, 17, 50, 1'b0);

		wait_idle();
		repeat (100) @(negedge clk);
		if (alloc_expected.size() != 0) begin
			errors++;
			$display("%0t: %0d response words never arrived", $time, alloc_expected.size());
		end
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

[flex_group_inode_allocator.f]
hdl/fgia_pkg.sv
hdl/fgia_if.sv
hdl/fgia_ram.sv
hdl/fgia_div.sv
hdl/fgia_ffz.sv
hdl/flex_group_inode_allocator.sv
hdl/fgia_chk.sv
tb/tb.sv
